### design/ramp_band_color_shader_top_defines.svh
// assertion macros for the ramp band color shader
// used by ramp_band_color_shader_top; no other dependencies
`ifndef RAMP_BAND_COLOR_SHADER_TOP_DEFINES_SVH
`define RAMP_BAND_COLOR_SHADER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition holds in the same cycle as the trigger
`define RBCS_ASSERT_NOW(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("rbcs assertion failed");

// condition holds in the cycle after the trigger
`define RBCS_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("rbcs assertion failed");

`else

`define RBCS_ASSERT_NOW(label, clk, rst_n, trig, cond)
`define RBCS_ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

### design/rbcs_pkg.sv
// constants, types and helper functions for the ramp band color shader
// no dependencies; used by ramp_band_color_shader_top
package rbcs_pkg;

    // register indexes
    localparam logic [2:0] REG_LOW_SHADE     = 3'd0;
    localparam logic [2:0] REG_HIGH_SHADE    = 3'd1;
    localparam logic [2:0] REG_BAND_COUNT    = 3'd2;
    localparam logic [2:0] REG_BAND_STRENGTH = 3'd3;
    localparam logic [2:0] REG_BAND_SOFTNESS = 3'd4;

    // register ranges and reset values
    localparam logic [14:0] SHADE_MAX     = 15'd16384;
    localparam logic [14:0] COUNT_MAX     = 15'd16384;
    localparam logic [12:0] STRENGTH_MAX  = 13'd4096;
    localparam logic [14:0] SOFT_MIN      = 15'd1966;
    localparam logic [14:0] SOFT_MAX      = 15'd32113;
    localparam logic [14:0] SHADE_RESET   = 15'd4096;
    localparam logic [14:0] SOFT_RESET    = 15'd16384;

    // 0.02 in q0.24
    localparam logic [23:0] EDGE_Q24      = 24'd335544;
    localparam logic [23:0] HALF_Q24      = 24'h800000;
    localparam logic [24:0] ONE_Q24       = 25'h1000000;
    localparam logic [22:0] DEN_RESET     = 23'(int'(SOFT_RESET) * 256 - int'(EDGE_Q24));

    // smoothstep and band constants
    localparam logic [16:0] T_ONE         = 17'd65536;
    localparam logic [17:0] W_THREE       = 18'd196608;
    localparam logic [48:0] RND_CURVE     = 49'h0_8000_0000;
    localparam logic [28:0] BAND_ONE      = 29'h1000_0000;
    localparam logic [58:0] RND_SHADE     = 59'h0_8000_0000;

    // divider layout
    localparam int DIV_BITS  = 2;
    localparam int DIV_STG   = 8;
    localparam int QBITS     = DIV_BITS * DIV_STG;
    localparam int DIV_BASE  = 3;
    localparam int DIV_LAST  = DIV_BASE + DIV_STG - 1;
    localparam int STG_BAND  = DIV_BASE + DIV_STG + 4;
    localparam int NUM_STG   = DIV_BASE + DIV_STG + 8;

    typedef struct packed {
        logic [31:0] color;
        logic [30:0] grad;
    } carry_t;

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [24:0] div_step(input logic [23:0] rem, input logic [22:0] den);
        logic [24:0] r2;
        logic [24:0] dx;
        r2 = {rem, 1'b0};
        dx = {2'b00, den};
        if (r2 >= dx)
        begin
            return {1'b1, 24'(r2 - dx)};
        end
        return {1'b0, r2[23:0]};
    endfunction

    // channel times q3.24 shade, rounded half up, saturated
    function automatic logic [7:0] shade_chan(input logic [7:0] c, input logic [26:0] shade);
        logic [35:0] p;
        logic [11:0] v;
        p = {28'b0, c} * {9'b0, shade};
        p = p + 36'h0_0080_0000;
        v = p[35:24];
        return (v > 12'd255) ? 8'hff : v[7:0];
    endfunction

endpackage

### design/ramp_band_color_shader_top.sv
// ramp band color shader, fully pipelined
// depends on rbcs_pkg and ramp_band_color_shader_top_defines.svh

// Takes one transaction per clock while in_stall is low and returns one shaded color per
// transaction, in order, on color_out through 19 register stages. The depth is
// set mostly by the band smoothstep divider, eight stages that each retire two quotient
// bits, followed by the cubic, band and channel multiplier stages. When out_stall holds a
// waiting result, the whole pipeline freezes and in_stall rises in the same cycle; nothing
// is lost or repeated. Register writes are taken at any time but must only be made while
// no transaction is in flight.

`include "ramp_band_color_shader_top_defines.svh"

module ramp_band_color_shader_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] color_in,
    input  logic [15:0] progress,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] color_out
);

    logic [14:0] low_shade_reg;
    logic [14:0] high_shade_reg;
    logic [14:0] band_count_reg;
    logic [12:0] band_strength_reg;
    logic [14:0] band_softness_reg;
    logic [22:0] den_reg;

    logic [rbcs_pkg::NUM_STG-1:0] vld_reg;
    logic adv;

    // config writes with saturation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_shade_reg     <= rbcs_pkg::SHADE_RESET;
            high_shade_reg    <= rbcs_pkg::SHADE_RESET;
            band_count_reg    <= '0;
            band_strength_reg <= '0;
            band_softness_reg <= rbcs_pkg::SOFT_RESET;
            den_reg           <= rbcs_pkg::DEN_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rbcs_pkg::REG_LOW_SHADE:
                    begin
                        low_shade_reg <= (cfg_data > rbcs_pkg::SHADE_MAX) ?
                                         rbcs_pkg::SHADE_MAX : cfg_data;
                    end
                    rbcs_pkg::REG_HIGH_SHADE:
                    begin
                        high_shade_reg <= (cfg_data > rbcs_pkg::SHADE_MAX) ?
                                          rbcs_pkg::SHADE_MAX : cfg_data;
                    end
                    rbcs_pkg::REG_BAND_COUNT:
                    begin
                        band_count_reg <= (cfg_data > rbcs_pkg::COUNT_MAX) ?
                                          rbcs_pkg::COUNT_MAX : cfg_data;
                    end
                    rbcs_pkg::REG_BAND_STRENGTH:
                    begin
                        band_strength_reg <= (cfg_data > 15'(rbcs_pkg::STRENGTH_MAX)) ?
                                             rbcs_pkg::STRENGTH_MAX : cfg_data[12:0];
                    end
                    rbcs_pkg::REG_BAND_SOFTNESS:
                    begin
                        if (cfg_data < rbcs_pkg::SOFT_MIN)
                        begin
                            band_softness_reg <= rbcs_pkg::SOFT_MIN;
                        end
                        else if (cfg_data > rbcs_pkg::SOFT_MAX)
                        begin
                            band_softness_reg <= rbcs_pkg::SOFT_MAX;
                        end
                        else
                        begin
                            band_softness_reg <= cfg_data;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            // smoothstep span, softness edge minus fixed edge
            den_reg <= 23'({band_softness_reg, 8'b0} - rbcs_pkg::EDGE_Q24);
        end
    end

    // global advance: freeze only when a result waits and is stalled
    assign adv       = !(vld_reg[rbcs_pkg::NUM_STG-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[rbcs_pkg::NUM_STG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[rbcs_pkg::NUM_STG-2:0], in_valid};
        end
    end

    // stage 1: gradient and band position
    logic signed [15:0] diff_s;
    logic signed [32:0] gprod_s;
    logic signed [32:0] grad_s;
    logic [30:0]        xprod;
    rbcs_pkg::carry_t   st1_carry_next;
    rbcs_pkg::carry_t   st1_carry_reg;
    logic [23:0]        st1_f_reg;

    assign diff_s  = $signed({1'b0, high_shade_reg}) - $signed({1'b0, low_shade_reg});
    assign gprod_s = $signed({1'b0, progress}) * diff_s;
    assign grad_s  = $signed({2'b00, low_shade_reg, 16'b0}) + gprod_s;
    assign xprod   = {15'b0, progress} * {16'b0, band_count_reg};

    always_comb
    begin
        st1_carry_next.color = color_in;
        st1_carry_next.grad  = grad_s[32] ? '0 : grad_s[30:0];
    end

    // stage 2: distance to nearest integer
    logic [23:0]      st2_d_next;
    logic [23:0]      st2_d_reg;
    rbcs_pkg::carry_t st2_carry_reg;

    assign st2_d_next = (st1_f_reg <= rbcs_pkg::HALF_Q24) ? st1_f_reg :
                        24'(rbcs_pkg::ONE_Q24 - {1'b0, st1_f_reg});

    // stage 3: clamp decisions and divider numerator
    logic             st3_tzero_next;
    logic             st3_tone_next;
    logic [23:0]      st3_num_next;
    logic [23:0]      st3_num_reg;
    logic             st3_tzero_reg;
    logic             st3_tone_reg;
    rbcs_pkg::carry_t st3_carry_reg;

    assign st3_tzero_next = (st2_d_reg <= rbcs_pkg::EDGE_Q24);
    assign st3_num_next   = st2_d_reg - rbcs_pkg::EDGE_Q24;
    assign st3_tone_next  = !st3_tzero_next && (st3_num_next >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st1_carry_reg <= st1_carry_next;
            st1_f_reg     <= xprod[23:0];
            st2_carry_reg <= st1_carry_reg;
            st2_d_reg     <= st2_d_next;
            st3_carry_reg <= st2_carry_reg;
            st3_num_reg   <= st3_num_next;
            st3_tzero_reg <= st3_tzero_next;
            st3_tone_reg  <= st3_tone_next;
        end
    end

    // divider stages, two quotient bits each
    logic [23:0]            div_rem_in   [rbcs_pkg::DIV_STG];
    logic [rbcs_pkg::QBITS-1:0] div_quo_in [rbcs_pkg::DIV_STG];
    logic [23:0]            div_rem_next [rbcs_pkg::DIV_STG];
    logic [rbcs_pkg::QBITS-1:0] div_quo_next [rbcs_pkg::DIV_STG];
    logic [23:0]            div_rem_reg  [rbcs_pkg::DIV_STG];
    logic [rbcs_pkg::QBITS-1:0] div_quo_reg [rbcs_pkg::DIV_STG];
    logic                   div_tzero_reg [rbcs_pkg::DIV_STG];
    logic                   div_tone_reg  [rbcs_pkg::DIV_STG];
    rbcs_pkg::carry_t       div_carry_reg [rbcs_pkg::DIV_STG];

    for (genvar gi = 0; gi < rbcs_pkg::DIV_STG; gi++)
    begin : g_div
        if (gi == 0)
        begin : g_first
            assign div_rem_in[gi] = st3_num_reg;
            assign div_quo_in[gi] = '0;
        end
        else
        begin : g_rest
            assign div_rem_in[gi] = div_rem_reg[gi-1];
            assign div_quo_in[gi] = div_quo_reg[gi-1];
        end

        always_comb
        begin
            logic [23:0]                rem_v;
            logic [rbcs_pkg::QBITS-1:0] quo_v;
            logic [24:0]                step_v;
            rem_v = div_rem_in[gi];
            quo_v = div_quo_in[gi];
            for (int k = 0; k < rbcs_pkg::DIV_BITS; k++)
            begin
                step_v = rbcs_pkg::div_step(rem_v, den_reg);
                rem_v  = step_v[23:0];
                quo_v  = {quo_v[rbcs_pkg::QBITS-2:0], step_v[24]};
            end
            div_rem_next[gi] = rem_v;
            div_quo_next[gi] = quo_v;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_rem_reg[gi] <= div_rem_next[gi];
                div_quo_reg[gi] <= div_quo_next[gi];
                if (gi == 0)
                begin
                    div_tzero_reg[gi] <= st3_tzero_reg;
                    div_tone_reg[gi]  <= st3_tone_reg;
                    div_carry_reg[gi] <= st3_carry_reg;
                end
                else
                begin
                    div_tzero_reg[gi] <= div_tzero_reg[gi-1];
                    div_tone_reg[gi]  <= div_tone_reg[gi-1];
                    div_carry_reg[gi] <= div_carry_reg[gi-1];
                end
            end
        end
    end

    // smoothstep, band factor, shade and channels
    logic [16:0]      t_next;
    logic [16:0]      t_reg;
    rbcs_pkg::carry_t t_carry_reg;
    logic [32:0]      sq_tt_next;
    logic [17:0]      sq_w_next;
    logic [32:0]      sq_tt_reg;
    logic [17:0]      sq_w_reg;
    rbcs_pkg::carry_t sq_carry_reg;
    logic [48:0]      cub_next;
    logic [48:0]      cub_reg;
    rbcs_pkg::carry_t cub_carry_reg;
    logic [48:0]      curve_sum;
    logic [16:0]      curve_reg;
    rbcs_pkg::carry_t curve_carry_reg;
    logic [29:0]      band_prod;
    logic [28:0]      band_next;
    logic [28:0]      band_reg;
    rbcs_pkg::carry_t band_carry_reg;
    logic [58:0]      prod_next;
    logic [58:0]      prod_reg;
    logic [31:0]      prod_color_reg;
    logic [58:0]      shade_sum;
    logic [26:0]      shade_reg;
    logic [31:0]      shade_color_reg;
    logic [31:0]      color_out_next;
    logic [31:0]      color_out_reg;

    assign t_next = div_tzero_reg[rbcs_pkg::DIV_STG-1] ? '0 :
                    div_tone_reg[rbcs_pkg::DIV_STG-1]  ? rbcs_pkg::T_ONE :
                    {1'b0, div_quo_reg[rbcs_pkg::DIV_STG-1]};

    assign sq_tt_next = {16'b0, t_reg} * {16'b0, t_reg};
    assign sq_w_next  = rbcs_pkg::W_THREE - {t_reg, 1'b0};
    assign cub_next   = {16'b0, sq_tt_reg} * {31'b0, sq_w_reg};
    assign curve_sum  = cub_reg + rbcs_pkg::RND_CURVE;
    assign band_prod  = {13'b0, curve_reg} * {17'b0, band_strength_reg};
    assign band_next  = (band_count_reg != '0) ?
                        (rbcs_pkg::BAND_ONE - band_prod[28:0]) : rbcs_pkg::BAND_ONE;
    assign prod_next  = {28'b0, band_carry_reg.grad} * {30'b0, band_reg};
    assign shade_sum  = prod_reg + rbcs_pkg::RND_SHADE;

    always_comb
    begin
        color_out_next[31:24] = shade_color_reg[31:24];
        color_out_next[23:16] = rbcs_pkg::shade_chan(shade_color_reg[23:16], shade_reg);
        color_out_next[15:8]  = rbcs_pkg::shade_chan(shade_color_reg[15:8], shade_reg);
        color_out_next[7:0]   = rbcs_pkg::shade_chan(shade_color_reg[7:0], shade_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg           <= t_next;
            t_carry_reg     <= div_carry_reg[rbcs_pkg::DIV_STG-1];
            sq_tt_reg       <= sq_tt_next;
            sq_w_reg        <= sq_w_next;
            sq_carry_reg    <= t_carry_reg;
            cub_reg         <= cub_next;
            cub_carry_reg   <= sq_carry_reg;
            curve_reg       <= curve_sum[48:32];
            curve_carry_reg <= cub_carry_reg;
            band_reg        <= band_next;
            band_carry_reg  <= curve_carry_reg;
            prod_reg        <= prod_next;
            prod_color_reg  <= band_carry_reg.color;
            shade_reg       <= shade_sum[58:32];
            shade_color_reg <= prod_color_reg;
            color_out_reg   <= color_out_next;
        end
    end

    assign color_out = color_out_reg;

    logic soft_in_range;
    logic div_checked;
    logic div_rem_ok;
    logic band_checked;

    assign soft_in_range = (band_softness_reg >= rbcs_pkg::SOFT_MIN) &&
                           (band_softness_reg <= rbcs_pkg::SOFT_MAX);
    assign div_checked   = vld_reg[rbcs_pkg::DIV_LAST] &&
                           !div_tzero_reg[rbcs_pkg::DIV_STG-1] &&
                           !div_tone_reg[rbcs_pkg::DIV_STG-1];
    assign div_rem_ok    = div_rem_reg[rbcs_pkg::DIV_STG-1] < {1'b0, den_reg};
    assign band_checked  = vld_reg[rbcs_pkg::STG_BAND] && (band_count_reg == '0);

    // softness must stay inside its saturation range
    `RBCS_ASSERT_NOW(a_soft_range, clk, rst_n, 1'b1, soft_in_range)
    // in the dividing case the remainder stays below the divisor
    `RBCS_ASSERT_NOW(a_div_rem, clk, rst_n, div_checked, div_rem_ok)
    // banding off leaves the band factor at exactly one
    `RBCS_ASSERT_NOW(a_band_off, clk, rst_n, band_checked, band_reg == rbcs_pkg::BAND_ONE)
    // a transaction in the last internal stage reaches the output on advance
    `RBCS_ASSERT_NEXT(a_deliver, clk, rst_n, vld_reg[rbcs_pkg::NUM_STG-2] && adv, out_valid)

endmodule
